// ===== hw/rtl/sirc_pkg.sv =====
package sirc_pkg;

   // Fixed field widths of the stream and register interfaces
   localparam int SAMPLE_BITS    = 16;
   localparam int CMD_BITS       = 2;
   localparam int TAP_INDEX_BITS = 10;
   localparam int TAP_COUNT_BITS = 11;
   localparam int MIX_BITS       = 16;

   localparam int REQ_DATA_BITS  = 64;
   localparam int RSP_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_IDX_BITS   = CSR_ADDR_BITS - 2;

   localparam int MAX_TAPS_DEF   = 1024;

   // Unity wet share in Q1.15
   localparam logic [MIX_BITS-1:0] MIX_ONE = 16'h8000;

   // Command codes carried in tuser
   localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_FRAME = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

   // Register indexes (byte address / 4)
   localparam logic [REG_IDX_BITS-1:0] REG_TAP_COUNT = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_MIX_GAIN  = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_ENABLE    = 2'd2;

endpackage

// ===== hw/rtl/sirc_ram.sv =====
module sirc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/stereo_ir_convolver_mix.sv =====
// Stereo impulse-response convolver with wet/dry mix. Items arrive on the req_ stream with
// the command in tuser: a tap load writes one Q1.15 tap into the tap table shared by both
// channels, a frame item pushes one stereo sample pair into the history memory and returns
// one mixed pair on rsp_, and a clear empties the history and rewinds its pointer. The wet
// sum runs over the first tap_count taps (capped at MAX_TAPS) against the most recent
// samples; the result is mix_gain * wet + (1 - mix_gain) * dry, rounded half up and
// saturated to 16 bits. With enable low or tap_count zero a frame comes back unchanged and
// the history is left alone. Loads and clears return nothing. A convolved frame makes one
// history read and one tap read per tap for n taps, n being tap_count capped at MAX_TAPS,
// feeding one multiply-accumulate per channel; the pipeline then drains and three mix
// stages (wet rounding, gain products, sum) lead to the result register. The input is
// ready again once the result register loads. A pass-through frame goes straight to the
// output state. The result register lets the next item in while a result waits; a new
// result waits in turn until the previous one is taken. Tap entries never loaded read
// back as garbage. History needs no clearing pass after reset or clear: a fill count
// masks slots not yet written since then. Registers (APB, byte address 4*i): 0 tap_count,
// 1 mix_gain (Q1.15, above 32768 acts as 32768), 2 enable. Write them only while the block
// is idle.
module stereo_ir_convolver_mix #(
   parameter int MAX_TAPS = sirc_pkg::MAX_TAPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: tap_index[9:0], tap_value[25:10], left_in[41:26], right_in[57:42], zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sirc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // req_tuser: command[1:0]
   input  logic [sirc_pkg::CMD_BITS-1:0]      req_tuser,
   // rsp_tdata: left_out[15:0], right_out[31:16]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sirc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sirc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sirc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sirc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   import sirc_pkg::*;

   localparam int SB        = SAMPLE_BITS;
   localparam int AW        = $clog2(MAX_TAPS);
   localparam int CW        = $clog2(MAX_TAPS + 1);
   localparam int PB        = 2 * SB;
   localparam int ACC_BITS  = PB + CW;
   localparam int MIXP_BITS = SB + MIX_BITS + 1;
   localparam int MIXS_BITS = MIXP_BITS + 1;

   localparam logic signed [SB-1:0]        SMAX    = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0]        SMIN    = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0]  ACC_RND = ACC_BITS'(1) <<< (SB - 2);
   localparam logic signed [MIXS_BITS-1:0] MIX_RND = MIXS_BITS'(1) <<< (MIX_BITS - 2);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_WET,
      S_MIX,
      S_SUM,
      S_OUT
   } state_type;

   // Shift the tap sum back to Q1.15, round half up, saturate
   function automatic logic signed [SB-1:0] wet_round(input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] t;
      t = (v + ACC_RND) >>> (SB - 1);
      if (t > ACC_BITS'(SMAX)) begin
         return SMAX;
      end else if (t < ACC_BITS'(SMIN)) begin
         return SMIN;
      end
      return t[SB-1:0];
   endfunction

   // Add wet and dry shares, drop the Q1.15 gain scale with rounding, saturate
   function automatic logic signed [SB-1:0] mix_round(input logic signed [MIXP_BITS-1:0] a,
                                                      input logic signed [MIXP_BITS-1:0] b);
      logic signed [MIXS_BITS-1:0] t;
      t = (MIXS_BITS'(a) + MIXS_BITS'(b) + MIX_RND) >>> (MIX_BITS - 1);
      if (t > MIXS_BITS'(SMAX)) begin
         return SMAX;
      end else if (t < MIXS_BITS'(SMIN)) begin
         return SMIN;
      end
      return t[SB-1:0];
   endfunction

   // ---------------------------------------------------------------- register port
   logic [TAP_COUNT_BITS-1:0] tap_count_ff;
   logic [MIX_BITS-1:0]       mix_gain_ff;
   logic                      enable_ff;
   logic                      csr_wr;
   logic [REG_IDX_BITS-1:0]   csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= '0;
         mix_gain_ff  <= MIX_ONE;
         enable_ff    <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_TAP_COUNT: tap_count_ff <= csr_pwdata[TAP_COUNT_BITS-1:0];
            REG_MIX_GAIN:  mix_gain_ff  <= csr_pwdata[MIX_BITS-1:0];
            REG_ENABLE:    enable_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_TAP_COUNT: csr_prdata = CSR_DATA_BITS'(tap_count_ff);
         REG_MIX_GAIN:  csr_prdata = CSR_DATA_BITS'(mix_gain_ff);
         REG_ENABLE:    csr_prdata = CSR_DATA_BITS'(enable_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- item fields
   logic [CMD_BITS-1:0]       cmd;
   logic [TAP_INDEX_BITS-1:0] tap_index;
   logic signed [SB-1:0]      tap_value;
   logic signed [SB-1:0]      left_in;
   logic signed [SB-1:0]      right_in;

   assign cmd       = req_tuser;
   assign tap_index = req_tdata[TAP_INDEX_BITS-1:0];
   assign tap_value = req_tdata[TAP_INDEX_BITS +: SB];
   assign left_in   = req_tdata[TAP_INDEX_BITS + SB +: SB];
   assign right_in  = req_tdata[TAP_INDEX_BITS + 2*SB +: SB];

   // ---------------------------------------------------------------- derived settings
   logic [CW-1:0]       n_lim;
   logic [MIX_BITS-1:0] mix_lim;
   logic [MIX_BITS-1:0] dry_gain;
   logic                active;

   assign n_lim    = (32'(tap_count_ff) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tap_count_ff);
   assign mix_lim  = (mix_gain_ff > MIX_ONE) ? MIX_ONE : mix_gain_ff;
   assign dry_gain = MIX_ONE - mix_lim;
   assign active   = enable_ff && (tap_count_ff != '0);

   // ---------------------------------------------------------------- control state
   state_type            state_ff;
   logic [AW-1:0]        hist_ptr_ff;
   logic [CW-1:0]        fill_ff;
   logic [AW-1:0]        rd_ptr_ff;
   logic [CW-1:0]        k_ff;
   logic [CW-1:0]        n_ff;
   logic signed [SB-1:0] xl_ff;
   logic signed [SB-1:0] xr_ff;
   logic signed [SB-1:0] res_l_ff;
   logic signed [SB-1:0] res_r_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   logic [AW-1:0] hist_ptr_in;
   logic [CW-1:0] fill_in;
   logic [AW-1:0] rd_ptr_in;
   logic          accept;
   logic          issue;
   logic          out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign issue      = (state_ff == S_MAC);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Circular pointer steps; the history reads walk backward from the newest slot
   assign hist_ptr_in = (hist_ptr_ff == AW'(MAX_TAPS - 1)) ? '0 : hist_ptr_ff + AW'(1);
   assign rd_ptr_in   = (rd_ptr_ff == '0) ? AW'(MAX_TAPS - 1) : rd_ptr_ff - AW'(1);
   assign fill_in     = (fill_ff == CW'(MAX_TAPS)) ? fill_ff : fill_ff + CW'(1);

   // ---------------------------------------------------------------- memories
   logic                 tap_wr_en;
   logic [SB-1:0]        tap_rd;
   logic                 hist_wr_en;
   logic [2*SB-1:0]      hist_rd;

   assign tap_wr_en  = accept && (cmd == CMD_LOAD) && (32'(tap_index) < 32'(MAX_TAPS));
   assign hist_wr_en = accept && (cmd == CMD_FRAME) && active;

   sirc_ram #(
      .WIDTH (SB),
      .DEPTH (MAX_TAPS)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_wr_en),
      .wr_addr (AW'(tap_index)),
      .wr_data (tap_value),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (tap_rd)
   );

   // Left sample in the low half, right in the high half
   sirc_ram #(
      .WIDTH (2 * SB),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_ptr_ff),
      .wr_data ({right_in, left_in}),
      .rd_addr (rd_ptr_ff),
      .rd_data (hist_rd)
   );

   // ---------------------------------------------------------------- MAC pipeline
   // Stage 1: memory read returns; stage 2: product registered; then accumulate.
   logic                       s1_valid_ff;
   logic                       s1_hv_ff;
   logic                       s2_valid_ff;
   logic signed [PB-1:0]       prod_l_ff;
   logic signed [PB-1:0]       prod_r_ff;
   logic signed [ACC_BITS-1:0] acc_l_ff;
   logic signed [ACC_BITS-1:0] acc_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
      // Mask history slots not written since reset or the last clear
      s1_hv_ff <= (k_ff < fill_ff);
      if (s1_valid_ff && s1_hv_ff) begin
         prod_l_ff <= $signed(tap_rd) * $signed(hist_rd[SB-1:0]);
         prod_r_ff <= $signed(tap_rd) * $signed(hist_rd[2*SB-1:SB]);
      end else begin
         prod_l_ff <= '0;
         prod_r_ff <= '0;
      end
      if (accept) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_l_ff <= acc_l_ff + ACC_BITS'(prod_l_ff);
         acc_r_ff <= acc_r_ff + ACC_BITS'(prod_r_ff);
      end
   end

   // ---------------------------------------------------------------- mix stages
   logic signed [SB-1:0]        wet_l_ff;
   logic signed [SB-1:0]        wet_r_ff;
   logic signed [MIXP_BITS-1:0] pm_l_ff;
   logic signed [MIXP_BITS-1:0] px_l_ff;
   logic signed [MIXP_BITS-1:0] pm_r_ff;
   logic signed [MIXP_BITS-1:0] px_r_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_WET) begin
         wet_l_ff <= wet_round(acc_l_ff);
         wet_r_ff <= wet_round(acc_r_ff);
      end
      if (state_ff == S_MIX) begin
         pm_l_ff <= $signed({1'b0, mix_lim}) * wet_l_ff;
         px_l_ff <= $signed({1'b0, dry_gain}) * xl_ff;
         pm_r_ff <= $signed({1'b0, mix_lim}) * wet_r_ff;
         px_r_ff <= $signed({1'b0, dry_gain}) * xr_ff;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hist_ptr_ff  <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken; in S_OUT the new one loads below instead
         if (rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (cmd)
                     CMD_FRAME: begin
                        xl_ff <= left_in;
                        xr_ff <= right_in;
                        if (active) begin
                           // Newest slot first, then walk back one slot per tap
                           rd_ptr_ff   <= hist_ptr_ff;
                           hist_ptr_ff <= hist_ptr_in;
                           fill_ff     <= fill_in;
                           k_ff        <= '0;
                           n_ff        <= n_lim;
                           state_ff    <= S_MAC;
                        end else begin
                           res_l_ff <= left_in;
                           res_r_ff <= right_in;
                           state_ff <= S_OUT;
                        end
                     end
                     CMD_CLEAR: begin
                        hist_ptr_ff <= '0;
                        fill_ff     <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_MAC: begin
               k_ff      <= k_ff + CW'(1);
               rd_ptr_ff <= rd_ptr_in;
               if ((k_ff + CW'(1)) == n_ff) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!s1_valid_ff && !s2_valid_ff) begin
                  state_ff <= S_WET;
               end
            end
            S_WET: begin
               state_ff <= S_MIX;
            end
            S_MIX: begin
               state_ff <= S_SUM;
            end
            S_SUM: begin
               res_l_ff <= mix_round(pm_l_ff, px_l_ff);
               res_r_ff <= mix_round(pm_r_ff, px_r_ff);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // Hold until the result register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {res_r_ff, res_l_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_TAPS))
      else $error("history fill count beyond depth");

   a_mac_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (k_ff < n_ff))
      else $error("tap counter ran past tap count");

   a_no_result_cmd: assert property (@(posedge clock) disable iff (reset)
      (accept && (cmd == CMD_LOAD || cmd == CMD_CLEAR)) |=> (state_ff == S_IDLE))
      else $error("load or clear left the sequencer busy");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> rsp_tvalid)
      else $error("finished result not presented");
`endif

endmodule

// ===== test/stereo_ir_convolver_mix_tb.sv =====
`timescale 1ns / 1ps

module stereo_ir_convolver_mix_tb;
   import sirc_pkg::*;

   // Command code the block ignores; the package names only the three it acts on
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 400;
   // Taps loaded up front; every filter length used stays within them
   localparam int LOADED_TAPS   = 128;
   // Idle margin allowed after the last owed frame is back
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 6 * (MAX_TAPS_DEF + SETTLE_CYCLES);
   localparam longint ACC_CLAMP = longint'(1) <<< 61;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } frame_type;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   // req_tdata: tap_index[9:0], tap_value[25:10], left_in[41:26], right_in[57:42], zero pad
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   // req_tuser: command[1:0]
   logic [CMD_BITS-1:0]      req_tuser   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   // rsp_tdata: left_out[15:0], right_out[31:16]
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   stereo_ir_convolver_mix #(
      .MAX_TAPS(MAX_TAPS_DEF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Shadow copy of the convolver: tap table, both histories, write pointer, registers.
   // Tap entries stay X until loaded; the stimulus never lets a frame read one of those.
   logic signed [SAMPLE_BITS-1:0]    tap_mem [MAX_TAPS_DEF];
   logic signed [SAMPLE_BITS-1:0]    hist_l  [MAX_TAPS_DEF];
   logic signed [SAMPLE_BITS-1:0]    hist_r  [MAX_TAPS_DEF];
   logic [TAP_INDEX_BITS-1:0]        hist_ptr = '0;
   logic [TAP_COUNT_BITS-1:0]        cfg_taps = '0;
   logic [MIX_BITS-1:0]              cfg_mix  = MIX_ONE;
   logic                             cfg_en   = 1'b0;

   frame_type mixed_frames_q[$];   // output frames owed by the block, oldest first
   int     errors       = 0;
   int     random_items = 0;
   bit     steady       = 1'b0; // set to hold both sides free of idle cycles

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < MAX_TAPS_DEF; i++) begin
         hist_l[i] = '0;
         hist_r[i] = '0;
      end
   end

   // ------------------------------------------------------------------
   // Predictor arithmetic
   // ------------------------------------------------------------------

   // Round half up: add half an LSB, then floor by arithmetic shift
   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Wet sum over the newest n history slots of one channel, then blend with the dry sample
   function automatic logic signed [SAMPLE_BITS-1:0] wet_dry_sample(
      input logic signed [SAMPLE_BITS-1:0] dry,
      input bit                            use_left,
      input int                            n
   );
      longint                        acc;
      longint                        wet;
      longint                        mix;
      longint                        sum;
      logic signed [SAMPLE_BITS-1:0] past;
      logic [TAP_INDEX_BITS-1:0]     slot;
      acc = 0;
      for (int k = 0; k < n; k++) begin
         slot = TAP_INDEX_BITS'(hist_ptr - k);   // wraps modulo the history depth
         past = use_left ? hist_l[slot] : hist_r[slot];
         acc += longint'(tap_mem[k]) * longint'(past);
         if (acc > ACC_CLAMP) acc = ACC_CLAMP;
         if (acc < -ACC_CLAMP) acc = -ACC_CLAMP;
      end
      wet = clip_sample(round_shift(acc, SAMPLE_BITS - 1));
      // mix_gain above unity acts as unity
      mix = (cfg_mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(cfg_mix);
      sum = mix * wet + (longint'(MIX_ONE) - mix) * longint'(dry);
      return clip_sample(round_shift(sum, 15));
   endfunction

   // Advance the shadow state by one accepted item and queue the frame it owes, if any
   task automatic step_convolver(
      input logic [CMD_BITS-1:0]           cmd,
      input logic [TAP_INDEX_BITS-1:0]     tap_index,
      input logic signed [SAMPLE_BITS-1:0] tap_value,
      input logic signed [SAMPLE_BITS-1:0] left_in,
      input logic signed [SAMPLE_BITS-1:0] right_in
   );
      int        n;
      frame_type f;
      case (cmd)
         CMD_LOAD: tap_mem[tap_index] = tap_value;
         CMD_CLEAR: begin
            for (int i = 0; i < MAX_TAPS_DEF; i++) begin
               hist_l[i] = '0;
               hist_r[i] = '0;
            end
            hist_ptr = '0;
         end
         CMD_FRAME: begin
            n = (cfg_taps > MAX_TAPS_DEF) ? MAX_TAPS_DEF : int'(cfg_taps);
            if (!cfg_en || n == 0) begin
               // pass through; history and pointer stay put
               f.left  = left_in;
               f.right = right_in;
            end else begin
               hist_l[hist_ptr] = left_in;
               hist_r[hist_ptr] = right_in;
               f.left  = wet_dry_sample(left_in, 1'b1, n);
               f.right = wet_dry_sample(right_in, 1'b0, n);
               hist_ptr = hist_ptr + 1'b1;
            end
            mixed_frames_q.push_back(f);
         end
         default: ;   // unused command: no result, no state change
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offer one item, hold it until accepted, then advance the shadow state.
   // Lower tvalid only when an idle gap is taken, so it never drops and rises in one step.
   task automatic send_item(
      input logic [CMD_BITS-1:0]           cmd,
      input logic [TAP_INDEX_BITS-1:0]     tap_index,
      input logic signed [SAMPLE_BITS-1:0] tap_value,
      input logic signed [SAMPLE_BITS-1:0] left_in,
      input logic signed [SAMPLE_BITS-1:0] right_in
   );
      if (!steady && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, right_in, left_in, tap_value, tap_index};
      do @(posedge clock); while (!req_tready);
      step_convolver(cmd, tap_index, tap_value, left_in, right_in);
   endtask

   // Random sample or tap, with the two extremes showing up often
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 16'sh8000;
      if (r == 1) return 16'sh7FFF;
      return 16'($urandom);
   endfunction

   // Mostly frames, some loads and clears, a little noise on the unused command
   task automatic send_random_item();
      int                  r;
      logic [CMD_BITS-1:0] cmd;
      r = $urandom_range(99);
      if (r < 70) cmd = CMD_FRAME;
      else if (r < 86) cmd = CMD_LOAD;
      else if (r < 93) cmd = CMD_CLEAR;
      else cmd = CMD_UNUSED;
      send_item(cmd, 10'($urandom), pick_sample(), pick_sample(), pick_sample());
      if (cmd != CMD_UNUSED) random_items++;
   endtask

   // Drop tvalid, hold until every owed frame is back, then let the block settle
   task automatic wait_idle(input int extra);
      req_tvalid <= 1'b0;
      while (mixed_frames_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access cycle until pready. psel stays high so
   // back-to-back writes need no extra edge; set_config drops it afterward.
   task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_TAP_COUNT: cfg_taps = value[TAP_COUNT_BITS-1:0];
         REG_MIX_GAIN:  cfg_mix  = value[MIX_BITS-1:0];
         REG_ENABLE:    cfg_en   = value[0];
         default: ;
      endcase
   endtask

   // Reprogram all three registers, only once the block has gone idle
   task automatic set_config(input int taps, input int mix, input int en);
      wait_idle(SETTLE_CYCLES);
      write_reg(REG_TAP_COUNT, taps);
      write_reg(REG_MIX_GAIN, mix);
      write_reg(REG_ENABLE, en);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Short hand-picked sequence: reset defaults, extreme taps and samples, every command,
   // dry-only and over-unity mix, zero taps, disabled block
   task automatic test_directed();
      // reset leaves the block disabled: the frame comes back as sent
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh8000, 16'sh7FFF);
      // loads act even while disabled
      send_item(CMD_LOAD, 10'd0, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_item(CMD_LOAD, 10'd1, 16'sh7FFF, 16'sh0000, 16'sh0000);
      send_item(CMD_LOAD, 10'd2, 16'sh4000, 16'sh1234, 16'shEDCB);
      send_item(CMD_LOAD, 10'd3, 16'shFFFF, 16'sh0000, 16'sh0000);
      send_item(CMD_LOAD, 10'd1023, 16'sh7FFF, 16'shFFFF, 16'shFFFF);

      set_config(4, MIX_ONE, 1);
      // -1.0 tap on a -1.0 sample drives the wet sum past full scale
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh8000, 16'sh8000);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh7FFF, 16'sh8000);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh0000, 16'sh0000);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh3039, 16'shFCF7);
      send_item(CMD_CLEAR, 10'd0, 16'sh0000, 16'sh0000, 16'sh0000);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh0001, 16'shFFFF);
      // unused command with every field lit: must change nothing
      send_item(CMD_UNUSED, 10'h3FF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh7FFF, 16'sh7FFF);

      // zero wet share: dry signal only
      set_config(4, 0, 1);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh8000, 16'sh7FFF);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh0100, 16'shFF00);

      // mix above unity acts as unity
      set_config(4, 16'hFFFF, 1);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh8000, 16'sh4000);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh2000, 16'sh8000);

      // enabled but no taps: pass through
      set_config(0, MIX_ONE, 1);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'sh5555, 16'shAAAA);

      // disabled with taps: pass through; a clear still acts
      set_config(4, 16384, 0);
      send_item(CMD_FRAME, 10'd0, 16'sh0000, 16'shAAAA, 16'sh5555);
      send_item(CMD_CLEAR, 10'd0, 16'sh0000, 16'sh0000, 16'sh0000);
   endtask

   // Fill the low part of the tap table, then convolve over all of it
   task automatic test_tap_table();
      for (int k = 0; k < LOADED_TAPS; k++) begin
         send_item(CMD_LOAD, TAP_INDEX_BITS'(k), pick_sample(), pick_sample(), pick_sample());
      end
      set_config(LOADED_TAPS, MIX_ONE, 1);
      repeat (4) begin
         send_item(CMD_FRAME, 10'($urandom), pick_sample(), pick_sample(), pick_sample());
      end
   endtask

   // Back-to-back items and results with neither side idling
   task automatic test_steady_stream();
      set_config(8, 24576, 1);
      steady = 1'b1;
      repeat (60) send_random_item();
      steady = 1'b0;
   endtask

   // Random register settings per phase; each phase starts with the block drained
   task automatic test_random_phases();
      int r;
      int taps;
      int mix;
      int len;
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 5) taps = 0;
         else if (r < 15) taps = LOADED_TAPS;
         else if (r < 30) taps = $urandom_range(LOADED_TAPS - 1, 25);
         else taps = $urandom_range(24, 1);
         r = $urandom_range(99);
         if (r < 20) mix = 0;
         else if (r < 40) mix = MIX_ONE;
         else if (r < 50) mix = $urandom_range(16'hFFFF, MIX_ONE + 1);
         else mix = $urandom_range(MIX_ONE);
         set_config(taps, mix, ($urandom_range(99) < 85) ? 1 : 0);
         len = $urandom_range(80, 30);
         repeat (len) send_random_item();
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: take each item, compare against the oldest owed frame, then pick
   // tready for the next edge
   // ------------------------------------------------------------------
   initial begin : result_check
      frame_type want;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (mixed_frames_q.size() == 0) begin
               $error("result item with no frame owed: rsp_tdata=%h", rsp_tdata);
               errors++;
            end else begin
               want = mixed_frames_q.pop_front();
               if (rsp_tdata[15:0] !== want.left) begin
                  $error("left_out: expected %0d, got %0d",
                         want.left, $signed(rsp_tdata[15:0]));
                  errors++;
               end
               if (rsp_tdata[31:16] !== want.right) begin
                  $error("right_out: expected %0d, got %0d",
                         want.right, $signed(rsp_tdata[31:16]));
                  errors++;
               end
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 7);
      end
   end

   // Watchdog: end the run once nothing has moved for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) quiet = 0;
         else quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_tap_table();
      test_steady_stream();
      test_random_phases();

      // drain: every owed frame back, then room for a full-length convolution
      wait_idle(MAX_TAPS_DEF + SETTLE_CYCLES);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
